// File: rtl/core/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Constants shared by the UTF-8 stream decoder: replacement code point,
// byte class masks and the scalar value range limits.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned ByteWidth = 8;
  // Value bits gathered before the final continuation byte (3 + 6 + 6).
  localparam int unsigned PartWidth = 15;
  // Results per transaction: 0 to 4.
  localparam int unsigned CntWidth  = 3;

  localparam logic [CpWidth-1:0] ReplacementCp = 21'h00FFFD;
  localparam logic [CpWidth-1:0] Min2Byte      = 21'h000080;
  localparam logic [CpWidth-1:0] Min3Byte      = 21'h000800;
  localparam logic [CpWidth-1:0] Min4Byte      = 21'h010000;
  localparam logic [CpWidth-1:0] SurrogateLo   = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrogateHi   = 21'h00DFFF;
  localparam logic [CpWidth-1:0] MaxScalar     = 21'h10FFFF;

  localparam logic [ByteWidth-1:0] ContMask  = 8'hC0;
  localparam logic [ByteWidth-1:0] ContTag   = 8'h80;
  localparam logic [ByteWidth-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteWidth-1:0] Lead2Tag  = 8'hC0;
  localparam logic [ByteWidth-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteWidth-1:0] Lead3Tag  = 8'hE0;
  localparam logic [ByteWidth-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteWidth-1:0] Lead4Tag  = 8'hF0;
  localparam logic [ByteWidth-1:0] ContBits  = 8'h3F;

endpackage

// File: rtl/core/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a UTF-8 byte stream into code points, substituting U+FFFD for
// malformed, overlong, surrogate and out-of-range sequences.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o    | byte_value_i, end_of_text_i
//  out     | output    | out_valid_o / out_stall_i  | code_point_o, replaced_o,
//          |           |                            | last_of_run_o
//
//  Each byte is decoded in the cycle it is accepted; its 0 to 4 results are
//  held in a result register and leave one per cycle unless the output stalls,
//  which holds the current result. A new byte is taken while the last result of
//  the previous byte leaves, so bytes with at most one result each sustain one
//  byte per cycle without stalls; a byte with more results holds off the next
//  until its last result leaves. Reset clears the open sequence and results.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
  import u8sd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_value_i,
  input  logic               end_of_text_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CpWidth-1:0] code_point_o,
  output logic               replaced_o,
  output logic               last_of_run_o
);

  // Sequence state
  logic [1:0]           exp_q, exp_d;
  logic [1:0]           seen_q, seen_d;
  logic [PartWidth-1:0] part_q, part_d;

  // Result register: results left, and the final one of the run
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [CpWidth-1:0]   last_cp_q, last_cp_d;
  logic                 last_rep_q, last_rep_d;

  logic                 in_acc;
  logic                 out_acc;
  logic                 pending;
  logic                 is_cont;
  logic [1:0]           seen_inc;
  logic [CpWidth-1:0]   shifted;
  logic                 bad_seq;
  logic [CntWidth-1:0]  flush_cnt;
  logic [CntWidth-1:0]  res_cnt;

  assign out_valid_o   = (cnt_q != '0);
  assign out_acc       = out_valid_o && !out_stall_i;
  assign last_of_run_o = (cnt_q == CntWidth'(1));
  assign code_point_o  = last_of_run_o ? last_cp_q : ReplacementCp;
  assign replaced_o    = last_of_run_o ? last_rep_q : 1'b1;

  // Take a byte once the result register is empty or its last result leaves
  assign in_stall_o = (cnt_q > CntWidth'(1)) || (last_of_run_o && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pending  = (exp_q != 2'd0);
  assign is_cont  = ((byte_value_i & ContMask) == ContTag);
  assign seen_inc = seen_q + 2'd1;
  assign shifted  = {part_q, byte_value_i[5:0]};
  // One replacement for the lead and one per continuation already received
  assign flush_cnt = CntWidth'(seen_q) + CntWidth'(1);

  always_comb begin
    unique case (exp_q)
      2'd1:    bad_seq = (shifted < Min2Byte);
      2'd2:    bad_seq = (shifted < Min3Byte) ||
                         ((shifted >= SurrogateLo) && (shifted <= SurrogateHi));
      default: bad_seq = (shifted < Min4Byte) || (shifted > MaxScalar);
    endcase
  end

  always_comb begin
    exp_d      = exp_q;
    seen_d     = seen_q;
    part_d     = part_q;
    res_cnt    = '0;
    last_cp_d  = ReplacementCp;
    last_rep_d = 1'b1;

    if (pending && is_cont) begin
      if (seen_inc >= exp_q) begin
        // Sequence complete
        res_cnt = CntWidth'(1);
        if (!bad_seq) begin
          last_cp_d  = shifted;
          last_rep_d = 1'b0;
        end
        exp_d  = 2'd0;
        seen_d = 2'd0;
        part_d = '0;
      end else if (end_of_text_i) begin
        res_cnt = CntWidth'(seen_inc) + CntWidth'(1);
        exp_d   = 2'd0;
        seen_d  = 2'd0;
        part_d  = '0;
      end else begin
        seen_d = seen_inc;
        part_d = shifted[PartWidth-1:0];
      end
    end else begin
      // Drop any open sequence, then treat the byte as a lead
      res_cnt = pending ? flush_cnt : '0;
      exp_d   = 2'd0;
      seen_d  = 2'd0;
      part_d  = '0;
      if (!byte_value_i[7]) begin
        res_cnt    = res_cnt + CntWidth'(1);
        last_cp_d  = CpWidth'(byte_value_i);
        last_rep_d = 1'b0;
      end else if ((byte_value_i & Lead2Mask) == Lead2Tag ||
                   (byte_value_i & Lead3Mask) == Lead3Tag ||
                   (byte_value_i & Lead4Mask) == Lead4Tag) begin
        if (end_of_text_i) begin
          res_cnt = res_cnt + CntWidth'(1);
        end else begin
          if ((byte_value_i & Lead2Mask) == Lead2Tag) begin
            exp_d  = 2'd1;
            part_d = PartWidth'(byte_value_i[4:0]);
          end else if ((byte_value_i & Lead3Mask) == Lead3Tag) begin
            exp_d  = 2'd2;
            part_d = PartWidth'(byte_value_i[3:0]);
          end else begin
            exp_d  = 2'd3;
            part_d = PartWidth'(byte_value_i[2:0]);
          end
        end
      end else begin
        res_cnt = res_cnt + CntWidth'(1);
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (out_acc) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
    if (in_acc) begin
      cnt_d = res_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= 2'd0;
      seen_q <= 2'd0;
      part_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        exp_q  <= exp_d;
        seen_q <= seen_d;
        part_q <= part_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      last_cp_q  <= last_cp_d;
      last_rep_q <= last_rep_d;
    end
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the UTF-8 stream decoder. Bytes are driven from a queue
// through a randomly idling valid/stall sender. A behavioral decoder
// predicts the code points each accepted byte produces. The monitor
// compares every result field against the oldest prediction, under random
// and long output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import u8sd_pkg::*;

  typedef struct packed {
    logic [CpWidth-1:0] cp;
    logic               repl;
    logic               last;
  } cp_result_t;

  typedef struct {
    logic [7:0] val;
    logic       eot;
    logic       drain;  // hold off until every predicted result has arrived
  } text_byte_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [7:0]         byte_value_i  = 8'h00;
  logic               end_of_text_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [CpWidth-1:0] code_point_o;
  logic               replaced_o;
  logic               last_of_run_o;

  text_byte_t text_bytes[$];
  cp_result_t expected_cps[$];

  // Decoder state of the predictor
  logic [1:0]         seq_need = '0;
  logic [1:0]         seq_got  = '0;
  logic [CpWidth-1:0] seq_code = '0;
  cp_result_t         step_res[4];
  int                 step_cnt;

  int   errors       = 0;
  int   items_taken  = 0;
  int   results_seen = 0;
  int   hold_left    = 0;
  logic hold_fired   = 1'b0;
  logic long_hold;

  utf8_stream_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_value_i  (byte_value_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .replaced_o    (replaced_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  task automatic emit_cp(input logic [CpWidth-1:0] cp, input logic repl);
    if (step_cnt < 4) begin
      step_res[step_cnt] = '{cp: cp, repl: repl, last: 1'b0};
      step_cnt++;
    end
  endtask

  task automatic drop_open_seq();
    for (int i = 0; i <= int'(seq_got); i++) emit_cp(ReplacementCp, 1'b1);
    seq_need = '0;
    seq_got  = '0;
    seq_code = '0;
  endtask

  task automatic start_seq(input logic [7:0] b);
    if (b < 8'h80) begin
      emit_cp(CpWidth'(b), 1'b0);
    end else if ((b & Lead2Mask) == Lead2Tag) begin
      seq_need = 2'd1;
      seq_got  = '0;
      seq_code = CpWidth'(b[4:0]);
    end else if ((b & Lead3Mask) == Lead3Tag) begin
      seq_need = 2'd2;
      seq_got  = '0;
      seq_code = CpWidth'(b[3:0]);
    end else if ((b & Lead4Mask) == Lead4Tag) begin
      seq_need = 2'd3;
      seq_got  = '0;
      seq_code = CpWidth'(b[2:0]);
    end else begin
      emit_cp(ReplacementCp, 1'b1);
    end
  endtask

  task automatic close_seq();
    logic bad;
    case (seq_need)
      2'd1:    bad = seq_code < Min2Byte;
      2'd2:    bad = seq_code < Min3Byte ||
                     (seq_code >= SurrogateLo && seq_code <= SurrogateHi);
      default: bad = seq_code < Min4Byte || seq_code > MaxScalar;
    endcase
    if (bad) emit_cp(ReplacementCp, 1'b1);
    else     emit_cp(seq_code, 1'b0);
    seq_need = '0;
    seq_got  = '0;
    seq_code = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    step_cnt = 0;
    if (seq_need != 0) begin
      if ((b & ContMask) == ContTag) begin
        seq_code = {seq_code[CpWidth-7:0], b[5:0]};
        seq_got  = seq_got + 2'd1;
        if (seq_got >= seq_need) close_seq();
      end else begin
        drop_open_seq();
        start_seq(b);
      end
    end else begin
      start_seq(b);
    end
    if (eot && seq_need != 0) drop_open_seq();
    if (step_cnt > 0) step_res[step_cnt-1].last = 1'b1;
    for (int i = 0; i < step_cnt; i++) expected_cps.push_back(step_res[i]);
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic add_byte(input logic [7:0] b, input logic eot);
    text_bytes.push_back('{val: b, eot: eot, drain: 1'b0});
  endtask

  function automatic logic [7:0] utf8_unit(input logic [20:0] cp, input int len,
                                           input int idx);
    int sh;
    sh = 6 * (len - 1 - idx);
    if (idx == 0) begin
      case (len)
        1:       return {1'b0, cp[6:0]};
        2:       return {3'b110, cp[10:6]};
        3:       return {4'b1110, cp[15:12]};
        default: return {5'b11110, cp[20:18]};
      endcase
    end
    return {2'b10, 6'(cp >> sh)};
  endfunction

  // Push the first `keep` bytes of the encoding, flagging end of text on the last.
  task automatic add_seq(input logic [20:0] cp, input int len, input int keep,
                         input logic eot_last);
    for (int i = 0; i < keep; i++) add_byte(utf8_unit(cp, len, i), eot_last && i == keep - 1);
  endtask

  function automatic logic [20:0] legal_cp(input int len);
    case (len)
      1:       return 21'($urandom_range(0, 'h7F));
      2:       return 21'($urandom_range('h80, 'h7FF));
      3:       return 21'($urandom_range('h800, 'hFFFF));
      default: return 21'($urandom_range('h10000, 'h10FFFF));
    endcase
  endfunction

  function automatic logic [20:0] illegal_cp(input int len);
    case (len)
      2: return 21'($urandom_range(0, 'h7F));
      3: return $urandom_range(0, 1) ? 21'($urandom_range(0, 'h7FF))
                                     : 21'($urandom_range('hD800, 'hDFFF));
      default: return $urandom_range(0, 1) ? 21'($urandom_range(0, 'hFFFF))
                                           : 21'($urandom_range('h110000, 'h1FFFFF));
    endcase
  endfunction

  initial begin
    int         kind;
    int         len;
    logic [7:0] b;
    logic       eot_last;
    text_byte_t tmp;

    // Directed: value extremes, overlong, surrogate, out of range,
    // bad continuation, stray continuation, invalid lead, end of text.
    add_byte(8'h00, 1'b0); add_byte(8'h7F, 1'b0);
    add_byte(8'hC2, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hC1, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hF4, 1'b0); add_byte(8'h8F, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hF4, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hF0, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h80, 1'b0); add_byte(8'hFF, 1'b0);
    add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);

    while (text_bytes.size() < 430) begin
      kind     = $urandom_range(0, 99);
      eot_last = ($urandom_range(0, 9) == 0);
      if (kind < 60) begin
        len = $urandom_range(1, 4);
        add_seq(legal_cp(len), len, len, eot_last);
      end else if (kind < 70) begin
        len = $urandom_range(2, 4);
        add_seq(illegal_cp(len), len, len, eot_last);
      end else if (kind < 78) begin
        len = $urandom_range(2, 4);
        add_seq(legal_cp(len), len, $urandom_range(1, len - 1), eot_last);
      end else if (kind < 88) begin
        add_byte(8'($urandom_range(0, 255)), eot_last);
      end else begin
        // break a sequence with a byte that is not a continuation
        len = $urandom_range(2, 4);
        add_seq(legal_cp(len), len, $urandom_range(1, len - 1), 1'b0);
        b = 8'($urandom_range(0, 255));
        if ((b & ContMask) == ContTag) b = b ^ 8'h40;
        add_byte(b, eot_last);
      end
    end

    tmp = text_bytes[25];  tmp.drain = 1'b1; text_bytes[25]  = tmp;
    tmp = text_bytes[330]; tmp.drain = 1'b1; text_bytes[330] = tmp;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_bytes.size() != 0 || expected_cps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_cps.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("tb_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- sender
  always @(posedge clk_i) begin
    logic quiet;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(byte_value_i, end_of_text_i);
        void'(text_bytes.pop_front());
        items_taken++;
      end
      // hold a stalled transaction unchanged
      if (!in_valid_i || !in_stall_o) begin
        quiet = (items_taken >= 200 && items_taken < 300);
        if (text_bytes.size() != 0 &&
            !(text_bytes[0].drain && expected_cps.size() != 0) &&
            !(!quiet && $urandom_range(0, 99) < 10)) begin
          in_valid_i    <= 1'b1;
          byte_value_i  <= text_bytes[0].val;
          end_of_text_i <= text_bytes[0].eot;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long output stall once the stream is under way, so the decoder backs up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_fired && items_taken >= 120) begin
        hold_fired <= 1'b1;
        hold_left  <= 80;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  assign long_hold = (hold_left != 0);

  // ---------------------------------------------------------------- receiver
  always @(posedge clk_i) begin
    cp_result_t exp_cp;
    logic       quiet;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_cps.size() == 0) begin
          $display("%0t: unexpected result, expected none, got cp %h rep %b last %b",
                   $realtime, code_point_o, replaced_o, last_of_run_o);
          errors++;
        end else begin
          exp_cp = expected_cps.pop_front();
          if (code_point_o !== exp_cp.cp) begin
            $display("%0t: code_point expected %h got %h", $realtime, exp_cp.cp, code_point_o);
            errors++;
          end
          if (replaced_o !== exp_cp.repl) begin
            $display("%0t: replaced expected %b got %b", $realtime, exp_cp.repl, replaced_o);
            errors++;
          end
          if (last_of_run_o !== exp_cp.last) begin
            $display("%0t: last_of_run expected %b got %b", $realtime, exp_cp.last,
                     last_of_run_o);
            errors++;
          end
        end
      end
      quiet = (results_seen >= 220 && results_seen < 340);
      out_stall_i <= long_hold || (!quiet && $urandom_range(0, 99) < 10);
    end
  end

endmodule
